FILE: rtl/rc4n_pkg.sv
// Package for the RC4 byte cipher with zero avoidance.
// Holds the shared constants, register indexes and the controller state type.
// No dependencies.
package rc4n_pkg;

  localparam int PermDepth   = 256;
  localparam int PermWidth   = 8;
  localparam int MaxKeyBytes = 16;
  localparam int RetryWidth  = 10;

  localparam int CfgAddrWidth = 5;
  localparam int CfgDataWidth = 64;

  localparam logic [1:0] RegKeyLow  = 2'd0;
  localparam logic [1:0] RegKeyHigh = 2'd1;
  localparam logic [1:0] RegKeyLen  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KS_RD,
    ST_KS_J,
    ST_KS_WI,
    ST_KS_WJ,
    ST_GEN_RD,
    ST_GEN_J,
    ST_GEN_SW,
    ST_GEN_OUT
  } state_e;

endpackage

FILE: rtl/rc4n_in_if.sv
// Input channel of the RC4 byte cipher: valid, ready and one byte item.
// No dependencies.
interface rc4n_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_char;
  logic       message_start;
  logic       message_end;

  modport source (output valid, output data_char, output message_start,
                  output message_end, input ready);
  modport sink (input valid, input data_char, input message_start,
                input message_end, output ready);
endinterface

FILE: rtl/rc4n_out_if.sv
// Output channel of the RC4 byte cipher: valid, ready and one result item.
// No dependencies.
interface rc4n_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_last;

  modport source (output valid, output out_char, output out_last, input ready);
  modport sink (input valid, input out_char, input out_last, output ready);
endinterface

FILE: rtl/rc4_stream_cipher_nonzero_core.sv
// Channel   Dir  Handshake            Item
// in_i      in   valid/ready          data_char[7:0], message_start, message_end
// out_o     out  valid/ready          out_char[7:0], out_last
// apb       in   psel/penable/pready  64-bit key words and key length
//
// A result is registered after GEN_J, GEN_SW and GEN_OUT, preceded by GEN_RD
// unless the previous byte prefetched the next permutation entry; the next byte
// can be accepted in the following cycle, and each extra keystream step repeats
// GEN_J to GEN_OUT. A message start fills the permutation, then runs the key
// schedule (KS_RD, then KS_J to KS_WJ per entry) on the single RAM port pair.
// Reset clears control state only; the permutation is undefined until a key
// schedule has run. The output register lets the next byte be accepted while a
// result waits; a byte that finishes into a full output register holds there.
// Depends on rc4n_pkg, rc4n_in_if, rc4n_out_if and rc4n_ram.
module rc4_stream_cipher_nonzero_core
  import rc4n_pkg::*;
#(
  parameter int MaxKeys = MaxKeyBytes
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  rc4n_in_if.sink                 in_i,
  rc4n_out_if.source              out_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [CfgDataWidth-1:0] pwdata,
  output logic [CfgDataWidth-1:0] prdata,
  output logic                    pready
);

  localparam int AddrW = $clog2(PermDepth);

  // Configuration registers.
  logic [63:0] key_lo_q, key_hi_q;
  logic [4:0]  key_len_q;
  logic [1:0]  reg_idx;
  logic        cfg_we;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q  <= '0;
      key_hi_q  <= '0;
      key_len_q <= 5'd1;
    end else if (cfg_we) begin
      case (reg_idx)
        RegKeyLow:  key_lo_q  <= pwdata;
        RegKeyHigh: key_hi_q  <= pwdata;
        RegKeyLen:  key_len_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegKeyLow:  prdata = key_lo_q;
      RegKeyHigh: prdata = key_hi_q;
      RegKeyLen:  prdata = {59'd0, key_len_q};
      default:    prdata = '0;
    endcase
  end

  // Controller and datapath registers.
  state_e                state_q, state_d;
  logic [AddrW-1:0]      cnt_q, cnt_d;
  logic [3:0]            k_q, k_d;
  logic [7:0]            i_q, i_d, j_q, j_d;
  logic [7:0]            si_q, si_d, sj_q, sj_d, t_q, t_d;
  logic                  fwd_q, fwd_d;
  logic [7:0]            fwd_val_q, fwd_val_d;
  logic                  pf_q, pf_d;
  logic [RetryWidth-1:0] tries_q, tries_d;
  logic [7:0]            data_q, data_d;
  logic                  last_q, last_d;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            out_char_q, out_char_d;
  logic                  out_last_q, out_last_d;

  // RAM port signals.
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;

  rc4n_ram #(
    .Width(PermWidth),
    .Depth(PermDepth)
  ) u_perm (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Helper values.
  logic         in_acc, out_free;
  logic [7:0]   sval, key_b, ks, res;
  logic [4:0]   len_eff;
  logic [127:0] key_all;
  logic         retry;

  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;
  // A read issued while its entry was being written returns stale data.
  assign sval     = fwd_q ? fwd_val_q : ram_rdata;
  assign key_all  = {key_hi_q, key_lo_q};
  assign key_b    = key_all[{k_q, 3'b000} +: 8];

  always_comb begin
    if (key_len_q == 5'd0) begin
      len_eff = 5'd1;
    end else if (key_len_q > 5'(MaxKeys)) begin
      len_eff = 5'(MaxKeys);
    end else begin
      len_eff = key_len_q;
    end
  end

  // Keystream byte after the swap has been applied.
  always_comb begin
    if (t_q == j_q) begin
      ks = si_q;
    end else if (t_q == i_q) begin
      ks = sj_q;
    end else begin
      ks = ram_rdata;
    end
    res = data_q ^ ks;
    if (res == 8'd0) begin
      res = data_q;
    end
  end

  assign retry = (res == 8'd0) && (tries_q != {RetryWidth{1'b1}});

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.message_start) begin
            state_d = ST_FILL;
          end else if (pf_q) begin
            state_d = ST_GEN_J;
          end else begin
            state_d = ST_GEN_RD;
          end
        end
      end
      ST_FILL:    if (cnt_q == 8'hFF) state_d = ST_KS_RD;
      ST_KS_RD:   state_d = ST_KS_J;
      ST_KS_J:    state_d = ST_KS_WI;
      ST_KS_WI:   state_d = ST_KS_WJ;
      ST_KS_WJ:   state_d = (cnt_q == 8'hFF) ? ST_GEN_RD : ST_KS_J;
      ST_GEN_RD:  state_d = ST_GEN_J;
      ST_GEN_J:   state_d = ST_GEN_SW;
      ST_GEN_SW:  state_d = ST_GEN_OUT;
      ST_GEN_OUT: begin
        if (retry) begin
          state_d = ST_GEN_J;
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // Outputs, RAM control and datapath updates.
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = cnt_q;
    ram_wdata   = cnt_q;
    ram_re      = 1'b0;
    ram_raddr   = cnt_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    i_d         = i_q;
    j_d         = j_q;
    si_d        = si_q;
    sj_d        = sj_q;
    t_d         = t_q;
    fwd_d       = fwd_q;
    fwd_val_d   = fwd_val_q;
    pf_d        = pf_q;
    tries_d     = tries_q;
    data_d      = data_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          data_d  = in_i.data_char;
          last_d  = in_i.message_end;
          tries_d = '0;
          if (in_i.message_start) begin
            cnt_d = '0;
            j_d   = '0;
            k_d   = '0;
            pf_d  = 1'b0;
          end else if (pf_q) begin
            i_d = i_q + 8'd1;
          end
        end
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = cnt_q;
        cnt_d     = cnt_q + 8'd1;
      end
      ST_KS_RD: begin
        ram_re    = 1'b1;
        ram_raddr = cnt_q;
        fwd_d     = 1'b0;
      end
      ST_KS_J: begin
        si_d      = sval;
        j_d       = j_q + sval + key_b;
        ram_re    = 1'b1;
        ram_raddr = j_d;
        fwd_d     = 1'b0;
      end
      ST_KS_WI: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        ram_wdata = ram_rdata;
      end
      ST_KS_WJ: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = si_q;
        ram_re    = 1'b1;
        ram_raddr = cnt_q + 8'd1;
        fwd_d     = (cnt_q + 8'd1) == j_q;
        fwd_val_d = si_q;
        cnt_d     = cnt_q + 8'd1;
        k_d       = (({1'b0, k_q} + 5'd1) >= len_eff) ? 4'd0 : k_q + 4'd1;
        if (cnt_q == 8'hFF) begin
          i_d = '0;
          j_d = '0;
        end
      end
      ST_GEN_RD: begin
        i_d       = i_q + 8'd1;
        ram_re    = 1'b1;
        ram_raddr = i_q + 8'd1;
        fwd_d     = 1'b0;
      end
      ST_GEN_J: begin
        si_d      = sval;
        j_d       = j_q + sval;
        ram_re    = 1'b1;
        ram_raddr = j_d;
        fwd_d     = 1'b0;
      end
      ST_GEN_SW: begin
        sj_d      = ram_rdata;
        ram_we    = 1'b1;
        ram_waddr = i_q;
        ram_wdata = ram_rdata;
        t_d       = si_q + ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = t_d;
      end
      ST_GEN_OUT: begin
        ram_we    = 1'b1;
        ram_waddr = j_q;
        ram_wdata = si_q;
        ram_raddr = i_q + 8'd1;
        // The keystream read stays in the RAM output while the item waits.
        if (retry || out_free) begin
          ram_re    = 1'b1;
          fwd_d     = (i_q + 8'd1) == j_q;
          fwd_val_d = si_q;
        end
        if (retry) begin
          i_d     = i_q + 8'd1;
          tries_d = tries_q + 1'b1;
        end else if (out_free) begin
          pf_d        = 1'b1;
          out_valid_d = 1'b1;
          out_char_d  = res;
          out_last_d  = last_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      k_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      fwd_q       <= 1'b0;
      pf_q        <= 1'b0;
      tries_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      k_q         <= k_d;
      i_q         <= i_d;
      j_q         <= j_d;
      fwd_q       <= fwd_d;
      pf_q        <= pf_d;
      tries_q     <= tries_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    si_q       <= si_d;
    sj_q       <= sj_d;
    t_q        <= t_d;
    fwd_val_q  <= fwd_val_d;
    data_q     <= data_d;
    last_q     <= last_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign in_i.ready     = (state_q == ST_IDLE);
  assign out_o.valid    = out_valid_q;
  assign out_o.out_char = out_char_q;
  assign out_o.out_last = out_last_q;

endmodule

FILE: rtl/rc4n_ram.sv
// Generic single-clock RAM, one write port and one read port, registered read.
// Reads return the old data when the same entry is written in that cycle.
// No dependencies.
module rc4n_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: tb/rc4_stream_cipher_nonzero_core_tb.sv
// Self-checking testbench for the RC4 byte cipher with zero avoidance.
// Predicts every output byte from its own copy of the permutation and key.
// Depends on rc4n_pkg, rc4n_in_if, rc4n_out_if and rc4_stream_cipher_nonzero_core.
`timescale 1ns / 1ps

module rc4_stream_cipher_nonzero_core_tb
  import rc4n_pkg::*;
;

  localparam int RetryLimit = 1 << RetryWidth;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } cipher_byte_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [CfgAddrWidth-1:0] paddr;
  logic [CfgDataWidth-1:0] pwdata;
  logic [CfgDataWidth-1:0] prdata;
  logic                    pready;

  rc4n_in_if  in_if ();
  rc4n_out_if out_if ();

  rc4_stream_cipher_nonzero_core uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predicted cipher state and key registers.
  logic [7:0]  perm [PermDepth];
  logic [7:0]  saved_perm [PermDepth];
  logic [7:0]  idx_i, idx_j, saved_i, saved_j;
  logic [63:0] key_lo, key_hi;
  logic [4:0]  key_len;

  cipher_byte_t ciphered_bytes[$];
  int unsigned  mismatches;
  bit           sender_idles;
  bit           receiver_idles;
  int           hold_out;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic void schedule_perm();
    int           n;
    int           k;
    int           len;
    logic [7:0]   j;
    logic [7:0]   t;
    logic [127:0] key;
    len = key_len;
    if (len < 1) len = 1;
    if (len > MaxKeyBytes) len = MaxKeyBytes;
    key = {key_hi, key_lo};
    for (n = 0; n < PermDepth; n++) perm[n] = n[7:0];
    j = 8'h00;
    k = 0;
    for (n = 0; n < PermDepth; n++) begin
      j = j + perm[n] + key[8*k +: 8];
      t = perm[n];
      perm[n] = perm[j];
      perm[j] = t;
      k++;
      if (k >= len) k = 0;
    end
    idx_i = 8'h00;
    idx_j = 8'h00;
  endfunction

  function automatic logic [7:0] stream_byte();
    logic [7:0] t;
    logic [7:0] s;
    idx_i = idx_i + 8'd1;
    idx_j = idx_j + perm[idx_i];
    t = perm[idx_i];
    perm[idx_i] = perm[idx_j];
    perm[idx_j] = t;
    s = perm[idx_i] + perm[idx_j];
    return perm[s];
  endfunction

  // Zero results fall back to the input byte; a zero input steps the stream again.
  function automatic logic [7:0] encrypt_byte(input logic [7:0] ch, input bit first);
    logic [7:0] res;
    int         tries;
    if (first) schedule_perm();
    res = 8'h00;
    tries = 0;
    while (tries < RetryLimit && res == 8'h00) begin
      res = ch ^ stream_byte();
      if (res == 8'h00) res = ch;
      tries++;
    end
    return res;
  endfunction

  // Keystream byte the next item would meet, without disturbing the state.
  function automatic logic [7:0] peek_stream(input bit first);
    logic [7:0] ks;
    int         n;
    for (n = 0; n < PermDepth; n++) saved_perm[n] = perm[n];
    saved_i = idx_i;
    saved_j = idx_j;
    if (first) schedule_perm();
    ks = stream_byte();
    for (n = 0; n < PermDepth; n++) perm[n] = saved_perm[n];
    idx_i = saved_i;
    idx_j = saved_j;
    return ks;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegKeyLow:  key_lo = val;
      RegKeyHigh: key_hi = val;
      RegKeyLen:  key_len = val[4:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic load_key(input logic [63:0] lo, input logic [63:0] hi,
                          input logic [4:0] len);
    write_reg(RegKeyLow, lo);
    write_reg(RegKeyHigh, hi);
    write_reg(RegKeyLen, {59'd0, len});
  endtask

  task automatic send_byte(input logic [7:0] ch, input bit first, input bit last_b);
    int gap;
    gap = sender_idles ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.data_char     <= ch;
    in_if.message_start <= first;
    in_if.message_end   <= last_b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    ciphered_bytes.push_back('{ch: encrypt_byte(ch, first), last: last_b});
  endtask

  task automatic drain_bytes();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (ciphered_bytes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_byte(input bit first);
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2, 3:    return peek_stream(first);
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Reset key, extreme data bytes, and a byte equal to the keystream.
  task automatic test_default_key();
    send_byte(8'h5A, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(peek_stream(1'b0), 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b1);
    drain_bytes();
  endtask

  // Full length, zero length, lengths beyond the maximum, and the shortest key.
  task automatic test_key_lengths();
    load_key('1, '1, 5'd16);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b1);
    drain_bytes();
    load_key({$urandom, $urandom}, {$urandom, $urandom}, 5'd0);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    drain_bytes();
    load_key({$urandom, $urandom}, {$urandom, $urandom}, 5'd31);
    send_byte(8'h7F, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    drain_bytes();
    load_key({$urandom, $urandom}, {$urandom, $urandom}, 5'd17);
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'hA5, 1'b0, 1'b1);
    drain_bytes();
    load_key(64'h0, '1, 5'd1);
    send_byte(8'h3C, 1'b1, 1'b0);
    send_byte(peek_stream(1'b0), 1'b0, 1'b1);
    drain_bytes();
  endtask

  // A key whose first keystream byte is zero, met by a zero data byte,
  // forces the generator to step again.
  task automatic test_zero_keystream();
    logic [63:0] lo;
    int          tries;
    lo = 64'h0;
    for (tries = 0; tries < 8192; tries++) begin
      lo = {$urandom, $urandom};
      key_lo  = lo;
      key_hi  = 64'h0;
      key_len = 5'd8;
      if (peek_stream(1'b1) == 8'h00) break;
    end
    load_key(lo, 64'h0, 5'd8);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(peek_stream(1'b0), 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    drain_bytes();
  endtask

  task automatic test_backpressure();
    int n;
    sender_idles = 1'b0;
    hold_out = 400;
    for (n = 0; n < 40; n++) send_byte(8'($urandom_range(0, 255)), n == 0, 1'b0);
    // The sender waits for every result before the message goes on.
    drain_bytes();
    for (n = 0; n < 10; n++) send_byte(8'($urandom_range(0, 255)), 1'b0, n == 9);
    sender_idles = 1'b1;
    drain_bytes();
  endtask

  task automatic test_random_messages();
    int          sent;
    int          msgs;
    int          len;
    int          n;
    bit          broken;
    bit          first;
    bit          last_b;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  klen;
    sent = 0;
    msgs = 0;
    while (sent < 1800) begin
      if (msgs % 12 == 11) begin
        drain_bytes();
        lo = ($urandom_range(0, 7) == 0) ? '1 : {$urandom, $urandom};
        hi = ($urandom_range(0, 7) == 0) ? '0 : {$urandom, $urandom};
        case ($urandom_range(0, 5))
          0:       klen = 5'd1;
          1:       klen = 5'd16;
          2:       klen = 5'd0;
          3:       klen = 5'($urandom_range(17, 31));
          default: klen = 5'($urandom_range(1, 16));
        endcase
        load_key(lo, hi, klen);
      end
      sender_idles   = $urandom_range(0, 3) != 0;
      receiver_idles = $urandom_range(0, 3) != 0;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
      broken = $urandom_range(0, 7) == 0;
      for (n = 0; n < len; n++) begin
        if (broken) begin
          first  = $urandom_range(0, 11) == 0;
          last_b = $urandom_range(0, 5) == 0;
        end else begin
          first  = n == 0;
          last_b = n == len - 1;
        end
        send_byte(pick_byte(first), first, last_b);
        sent++;
      end
      msgs++;
    end
    drain_bytes();
  endtask

  initial begin : receiver
    int stall;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_out > 0) begin
        stall = hold_out;
        hold_out = 0;
      end else begin
        stall = receiver_idles ? $urandom_range(0, 17) : 0;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin : check_out
    cipher_byte_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (ciphered_bytes.size() == 0) begin
        $display("%0t: unexpected item out_char %02h out_last %0b", $time,
                 out_if.out_char, out_if.out_last);
        mismatches++;
      end else begin
        want = ciphered_bytes.pop_front();
        if (out_if.out_char !== want.ch) begin
          $display("%0t: out_char expected %02h actual %02h", $time, want.ch,
                   out_if.out_char);
          mismatches++;
        end
        if (out_if.out_last !== want.last) begin
          $display("%0t: out_last expected %0b actual %0b", $time, want.last,
                   out_if.out_last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    mismatches     = 0;
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
    hold_out       = 0;
    idx_i          = 8'h00;
    idx_j          = 8'h00;
    key_lo         = 64'h0;
    key_hi         = 64'h0;
    key_len        = 5'd1;
    rst_ni              <= 1'b0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    in_if.valid         <= 1'b0;
    in_if.data_char     <= 8'h00;
    in_if.message_start <= 1'b0;
    in_if.message_end   <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_key();
    test_key_lengths();
    test_zero_keystream();
    test_backpressure();
    test_random_messages();

    drain_bytes();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && ciphered_bytes.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
